@@ rtl/core/fractal_escape_time_pixel_unit_macros.svh @@
// assertion macros for the escape-time pixel unit checker
`ifndef FRACTAL_ESCAPE_TIME_PIXEL_UNIT_MACROS_SVH
`define FRACTAL_ESCAPE_TIME_PIXEL_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define FETP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define FETP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/fetp_pkg.sv @@
// shared types, constants and helpers for the escape-time pixel unit
`timescale 1ns / 1ps
`default_nettype none

package fetp_pkg;

	localparam int COORD_W     = 32;
	localparam int STEP_W      = 31;
	localparam int IDX_W       = 12;
	localparam int ITER_OUT_W  = 16;
	localparam int BRIGHT_W    = 8;
	localparam int BIDX_W      = 3;
	localparam int FRAC_BITS   = 26;
	localparam int PROD_W      = 64;
	localparam int SUM_W       = 48;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 32;
	localparam int BRIGHT_SCALE = 65025;

	localparam int DEF_MAX_DIM   = 4096;
	localparam int DEF_ITER_BITS = 16;

	// register reset values
	localparam logic [COORD_W-1:0]    RST_ORIGIN_RE  = 32'hF800_0000;
	localparam logic [COORD_W-1:0]    RST_ORIGIN_IM  = 32'hF800_0000;
	localparam logic [STEP_W-1:0]     RST_PIXEL_STEP = 31'd262144;
	localparam logic [ITER_OUT_W-1:0] RST_MAX_ITER   = 16'd256;
	localparam logic [COORD_W-1:0]    RST_ESCAPE_SQ  = 32'h1000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_JULIA_MODE = 4'd0,
		CFG_ORIGIN_RE  = 4'd1,
		CFG_ORIGIN_IM  = 4'd2,
		CFG_PIXEL_STEP = 4'd3,
		CFG_CONST_RE   = 4'd4,
		CFG_CONST_IM   = 4'd5,
		CFG_MAX_ITER   = 4'd6,
		CFG_ESCAPE_SQ  = 4'd7
	} cfg_idx_t;

	typedef struct packed {
		logic                      julia_mode;
		logic signed [COORD_W-1:0] origin_re;
		logic signed [COORD_W-1:0] origin_im;
		logic [STEP_W-1:0]         pixel_step;
		logic signed [COORD_W-1:0] const_re;
		logic signed [COORD_W-1:0] const_im;
		logic [ITER_OUT_W-1:0]     max_iter;
		logic [COORD_W-1:0]        escape_sq;
	} cfg_regs_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAP,
		ST_POINT,
		ST_SQ,
		ST_STEP,
		ST_BR_INIT,
		ST_BR_SQ,
		ST_BR_CMP,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic              capture;
		logic              mul_en;
		logic              mul_map;
		logic              load_point;
		logic              upd_z;
		logic              cnt_inc;
		logic              rhs_load;
		logic              ksq_load;
		logic              k_cmp;
		logic              out_load;
		logic [BIDX_W-1:0] bidx;
	} cmd_t;

	typedef struct packed {
		logic limit_zero;
		logic escape;
		logic last_iter;
		logic k_fits;
	} status_t;

	// clip a wide signed value to the 32-bit signed range
	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic fits;
		fits = (v[SUM_W-1:COORD_W-1] == '0) || (v[SUM_W-1:COORD_W-1] == '1);
		if (fits) begin
			return v[COORD_W-1:0];
		end else if (v[SUM_W-1]) begin
			return {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			return {1'b0, {(COORD_W-1){1'b1}}};
		end
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/fetp_channels.sv @@
// handshake channel interfaces: pixel in, result out, register writes
`timescale 1ns / 1ps
`default_nettype none

interface fetp_pixel_if import fetp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] col;
	logic [IDX_W-1:0] row;

	modport source (output valid, output col, output row, input ready);
	modport sink (input valid, input col, input row, output ready);
endinterface

interface fetp_result_if import fetp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [BRIGHT_W-1:0]   brightness;
	logic [ITER_OUT_W-1:0] iter_count;

	modport source (output valid, output brightness, output iter_count, input ready);
	modport sink (input valid, input brightness, input iter_count, output ready);
endinterface

interface fetp_cfg_if import fetp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/fetp_ctrl.sv @@
// controller state machine: sequences mapping, iteration and brightness search
`timescale 1ns / 1ps
`default_nettype none

module fetp_ctrl import fetp_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	input  wire status_t sts,
	output cmd_t         cmd
);

	state_t            state_q, state_d;
	logic              first_q;
	logic [BIDX_W-1:0] bidx_q;
	logic              out_valid_q;
	logic              in_fire;
	logic              out_free;

	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) state_d = ST_MAP;
			end
			ST_MAP:   state_d = ST_POINT;
			ST_POINT: state_d = sts.limit_zero ? ST_FIN : ST_SQ;
			ST_SQ:    state_d = ST_STEP;
			ST_STEP: begin
				if (first_q) state_d = ST_SQ;
				else if (sts.escape) state_d = ST_BR_INIT;
				else if (sts.last_iter) state_d = ST_FIN;
				else state_d = ST_SQ;
			end
			ST_BR_INIT: state_d = ST_BR_SQ;
			ST_BR_SQ:   state_d = ST_BR_CMP;
			ST_BR_CMP:  state_d = (bidx_q == '0) ? ST_FIN : ST_BR_SQ;
			ST_FIN: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		cmd.bidx = bidx_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_MAP: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_map = 1'b1;
			end
			ST_POINT:   cmd.load_point = 1'b1;
			ST_SQ:      cmd.mul_en = 1'b1;
			ST_STEP: begin
				cmd.upd_z   = 1'b1;
				cmd.cnt_inc = !first_q && !sts.escape;
			end
			ST_BR_INIT: cmd.rhs_load = 1'b1;
			ST_BR_SQ:   cmd.ksq_load = 1'b1;
			ST_BR_CMP:  cmd.k_cmp = 1'b1;
			ST_FIN:     cmd.out_load = out_free;
			default:    cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			first_q     <= 1'b0;
			bidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_POINT) first_q <= 1'b1;
			else if (state_q == ST_STEP) first_q <= 1'b0;
			if (state_q == ST_BR_INIT) bidx_q <= '1;
			else if (state_q == ST_BR_CMP) bidx_q <= bidx_q - 1'b1;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/fetp_datapath.sv @@
// datapath: point mapping, z update, escape test and brightness search
`timescale 1ns / 1ps
`default_nettype none

module fetp_datapath import fetp_pkg::*; #(
	parameter int MAX_DIM   = DEF_MAX_DIM,
	parameter int ITER_BITS = DEF_ITER_BITS
) (
	input  wire logic                  clk,
	input  wire cmd_t                  cmd,
	output status_t                    sts,
	input  wire cfg_regs_t             regs,
	input  wire logic [IDX_W-1:0]      col,
	input  wire logic [IDX_W-1:0]      row,
	output logic [BRIGHT_W-1:0]        brightness,
	output logic [ITER_OUT_W-1:0]      iter_count
);

	localparam int XW = (ITER_BITS > ITER_OUT_W) ? ITER_BITS : ITER_OUT_W;
	localparam int RW = 2 * BRIGHT_W + ITER_BITS;

	logic [IDX_W-1:0]          col_q, row_q;
	logic [IDX_W-1:0]          col_c, row_c;
	logic signed [COORD_W-1:0] zre_q, zim_q, cre_q, cim_q;
	logic signed [PROD_W-1:0]  p0_q, p1_q, p2_q;
	logic signed [COORD_W-1:0] a0, b0, a1, b1, a2, b2;
	logic [ITER_BITS-1:0]      n_q;
	logic [ITER_BITS-1:0]      limit;
	logic [XW-1:0]             mi_x, cap_x;
	logic [RW-1:0]             rhs_q;
	logic [2*BRIGHT_W-1:0]     ksq_q;
	logic [BRIGHT_W-1:0]       k_q, mask, k_try;
	logic [BRIGHT_W-1:0]       bright_q;
	logic [ITER_OUT_W-1:0]     iter_q;
	logic signed [COORD_W-1:0] pre, pim, nre, nim;
	logic signed [PROD_W-1:0]  diff, sh_re, sh_im;
	logic [PROD_W-1:0]         mag, thresh;

	// index clamp to the frame size
	assign col_c = (32'(col) > 32'(MAX_DIM - 1)) ? IDX_W'(MAX_DIM - 1) : col;
	assign row_c = (32'(row) > 32'(MAX_DIM - 1)) ? IDX_W'(MAX_DIM - 1) : row;

	// iteration limit clipped to the counter range
	assign mi_x  = XW'(regs.max_iter);
	assign cap_x = XW'({ITER_BITS{1'b1}});
	assign limit = (mi_x > cap_x) ? ITER_BITS'(cap_x) : ITER_BITS'(mi_x);

	// three multipliers, the first two shared: index scaling or the z products
	always_comb begin
		if (cmd.mul_map) begin
			a0 = COORD_W'(col_q);
			b0 = COORD_W'(regs.pixel_step);
			a1 = COORD_W'(row_q);
			b1 = COORD_W'(regs.pixel_step);
		end else begin
			a0 = zre_q;
			b0 = zre_q;
			a1 = zim_q;
			b1 = zim_q;
		end
		a2 = zre_q;
		b2 = zim_q;
	end

	assign pre = sat32(SUM_W'(p0_q) + SUM_W'(regs.origin_re));
	assign pim = sat32(SUM_W'(p1_q) + SUM_W'(regs.origin_im));

	assign diff  = p0_q - p1_q;
	assign sh_re = diff >>> FRAC_BITS;
	assign sh_im = p2_q >>> (FRAC_BITS - 1);
	assign nre   = sat32(SUM_W'(sh_re) + SUM_W'(cre_q));
	assign nim   = sat32(SUM_W'(sh_im) + SUM_W'(cim_q));

	assign mag    = PROD_W'($unsigned(p0_q)) + PROD_W'($unsigned(p1_q));
	assign thresh = PROD_W'({regs.escape_sq, {FRAC_BITS{1'b0}}});

	assign mask  = BRIGHT_W'(1) << cmd.bidx;
	assign k_try = k_q | mask;

	assign sts.limit_zero = (limit == '0);
	assign sts.escape     = (mag > thresh);
	assign sts.last_iter  = (({1'b0, n_q} + (ITER_BITS + 1)'(1)) == {1'b0, limit});
	assign sts.k_fits     = ((RW'(ksq_q) * RW'(limit)) <= rhs_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			col_q <= col_c;
			row_q <= row_c;
		end
		if (cmd.mul_en) begin
			p0_q <= a0 * b0;
			p1_q <= a1 * b1;
			p2_q <= a2 * b2;
		end
		if (cmd.load_point) begin
			zre_q <= pre;
			zim_q <= pim;
			cre_q <= regs.julia_mode ? regs.const_re : pre;
			cim_q <= regs.julia_mode ? regs.const_im : pim;
			n_q   <= '0;
			k_q   <= '0;
		end
		if (cmd.upd_z) begin
			zre_q <= nre;
			zim_q <= nim;
		end
		if (cmd.cnt_inc) n_q <= n_q + 1'b1;
		if (cmd.rhs_load) rhs_q <= RW'(BRIGHT_SCALE) * RW'(n_q);
		if (cmd.ksq_load) ksq_q <= (2*BRIGHT_W)'(k_try) * (2*BRIGHT_W)'(k_try);
		if (cmd.k_cmp && sts.k_fits) k_q <= k_try;
		if (cmd.out_load) begin
			bright_q <= k_q;
			iter_q   <= ITER_OUT_W'(n_q);
		end
	end

	assign brightness = bright_q;
	assign iter_count = iter_q;

endmodule

`default_nettype wire

@@ rtl/core/fractal_escape_time_pixel_unit.sv @@
// top level of the escape-time pixel unit: register file, controller, datapath
//
//  channel  | dir | payload                      | handshake
//  ---------+-----+------------------------------+-------------------
//  pixel    | in  | col[11:0], row[11:0]         | valid / ready
//  result   | out | brightness[7:0], iter_count  | valid / ready
//  cfg      | in  | index[3:0], data[31:0]       | valid / ready (ready tied high)
//
// one pixel at a time; each escape-loop round is a multiply step, then a z update with escape
// test, through three 32x32 multipliers, the first two shared with the index mapping
// an escaping point then runs a bit-serial brightness search; a zero limit skips the loop
// the result register frees the core: a new word is taken while a result waits,
// a stalled result only holds the core at its final write
// arst_n clears control state and loads the register defaults
`timescale 1ns / 1ps
`default_nettype none

module fractal_escape_time_pixel_unit import fetp_pkg::*; #(
	parameter int MAX_DIM   = DEF_MAX_DIM,
	parameter int ITER_BITS = DEF_ITER_BITS
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	fetp_pixel_if.sink     pixel,
	fetp_result_if.source  result,
	fetp_cfg_if.sink       cfg
);

	cfg_regs_t regs_q;
	cmd_t      cmd;
	status_t   sts;

	// register writes are always taken
	assign cfg.ready = 1'b1;

	// configuration registers, decoded by index; unknown indexes drop the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.julia_mode <= 1'b0;
			regs_q.origin_re  <= RST_ORIGIN_RE;
			regs_q.origin_im  <= RST_ORIGIN_IM;
			regs_q.pixel_step <= RST_PIXEL_STEP;
			regs_q.const_re   <= '0;
			regs_q.const_im   <= '0;
			regs_q.max_iter   <= RST_MAX_ITER;
			regs_q.escape_sq  <= RST_ESCAPE_SQ;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_JULIA_MODE: regs_q.julia_mode <= cfg.data[0];
				CFG_ORIGIN_RE:  regs_q.origin_re  <= cfg.data;
				CFG_ORIGIN_IM:  regs_q.origin_im  <= cfg.data;
				CFG_PIXEL_STEP: regs_q.pixel_step <= cfg.data[STEP_W-1:0];
				CFG_CONST_RE:   regs_q.const_re   <= cfg.data;
				CFG_CONST_IM:   regs_q.const_im   <= cfg.data;
				CFG_MAX_ITER:   regs_q.max_iter   <= cfg.data[ITER_OUT_W-1:0];
				CFG_ESCAPE_SQ:  regs_q.escape_sq  <= cfg.data;
				default: ;
			endcase
		end
	end

	// sequencer: owns the pixel and result handshakes and the result valid flag
	fetp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.in_ready  (pixel.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// arithmetic: mapping, squaring, saturation, escape compare, brightness
	fetp_datapath #(
		.MAX_DIM   (MAX_DIM),
		.ITER_BITS (ITER_BITS)
	) u_datapath (
		.clk        (clk),
		.cmd        (cmd),
		.sts        (sts),
		.regs       (regs_q),
		.col        (pixel.col),
		.row        (pixel.row),
		.brightness (result.brightness),
		.iter_count (result.iter_count)
	);

endmodule

`default_nettype wire

@@ rtl/core/fetp_checker.sv @@
// port-level checker for the escape-time pixel unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "fractal_escape_time_pixel_unit_macros.svh"

module fetp_checker import fetp_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [BRIGHT_W-1:0]   brightness,
	input wire logic [ITER_OUT_W-1:0] iter_count
);

	`FETP_ASSERT_NXT(a_res_hold, out_valid && !out_ready, out_valid, "result word dropped while stalled")
	`FETP_ASSERT_NXT(a_res_stable, out_valid && !out_ready, $stable(brightness) && $stable(iter_count), "result payload changed while stalled")
	`FETP_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready, "pixel word taken while a pixel is in flight")
	`FETP_ASSERT_NOW(a_bright_count, out_valid && (brightness != '0), iter_count != '0, "nonzero brightness with zero iteration count")

endmodule

bind fractal_escape_time_pixel_unit fetp_checker u_fetp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (pixel.valid),
	.in_ready   (pixel.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.brightness (result.brightness),
	.iter_count (result.iter_count)
);

`default_nettype wire

@@ tb/tb_fractal_escape_time_pixel_unit.sv @@
// self-checking testbench for the escape-time pixel unit: pixel words in, escape counts out
`timescale 1ns / 1ps

module tb_fractal_escape_time_pixel_unit;
	import fetp_pkg::*;

	// the longest wait with no word moving is one pixel run to the full 16-bit limit; leave lots of room
	localparam int WATCHDOG_LIMIT = 400000;
	// the receiver goes deaf for this long, several pixels' worth, so the unit backs up
	localparam int HOLD_CYCLES    = 3000;
	localparam int HOLD_FIRST_AT  = 600;
	localparam int HOLD_SPACING   = 700;
	// quiet time after the last result, well over the longest non-iterating path
	localparam int DRAIN_CYCLES   = 64;
	localparam int RANDOM_PHASES  = 14;
	localparam int PHASE_PIXELS   = 134;
	localparam int MAX_PRINTED    = 40;

	localparam longint COORD_MAX = (longint'(1) <<< 31) - 1;
	localparam longint COORD_MIN = -(longint'(1) <<< 31);

	typedef struct packed {
		logic [IDX_W-1:0] col;
		logic [IDX_W-1:0] row;
	} pixel_word_t;

	typedef struct packed {
		logic [BRIGHT_W-1:0]   brightness;
		logic [ITER_OUT_W-1:0] iter_count;
	} pixel_result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} reg_write_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	fetp_pixel_if  pixel_ch();
	fetp_result_if result_ch();
	fetp_cfg_if    cfg_ch();

	fractal_escape_time_pixel_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow of the register file, only touched while the unit is idle
	cfg_regs_t regs;

	pixel_word_t   pending_pixels[$];
	pixel_result_t expected_results[$];
	reg_write_t    reg_plan[$];

	// prediction made at an input accept, held in a register for the monitor
	pixel_result_t predicted_word;
	logic          predicted_valid;

	int  pixels_queued   = 0;
	int  inputs_accepted = 0;
	int  results_checked = 0;
	int  mismatches      = 0;
	int  send_gap        = 0;
	int  sink_wait       = 0;
	int  hold_left       = 0;
	int  next_hold_at    = HOLD_FIRST_AT;
	int  quiet_cycles    = 0;
	bit  steady_flow     = 1'b0;

	// clip to the signed 32-bit coordinate range
	function automatic longint clip_coord(input longint v);
		if (v > COORD_MAX) begin
			return COORD_MAX;
		end
		if (v < COORD_MIN) begin
			return COORD_MIN;
		end
		return v;
	endfunction

	// escape-time predictor: map the pixel, iterate z*z + c, then scale the count
	function automatic pixel_result_t escape_time(input logic [IDX_W-1:0] c,
			input logic [IDX_W-1:0] r, input cfg_regs_t rg);
		longint        step, pre, pim, zre, zim, cre, cim, nre, nim;
		longint        lim, n, k;
		logic [63:0]   rr, ii, mag, thresh;
		pixel_result_t o;
		step = longint'(rg.pixel_step);
		pre = clip_coord(longint'($signed(rg.origin_re)) + longint'(c) * step);
		pim = clip_coord(longint'($signed(rg.origin_im)) + longint'(r) * step);
		zre = pre;
		zim = pim;
		if (rg.julia_mode) begin
			cre = longint'($signed(rg.const_re));
			cim = longint'($signed(rg.const_im));
		end else begin
			cre = pre;
			cim = pim;
		end
		// 16-bit limit never exceeds the counter, so no capping here
		lim = longint'(rg.max_iter);
		thresh = 64'(rg.escape_sq) << FRAC_BITS;
		n = 0;
		while (n < lim) begin
			// arithmetic shift floors toward minus infinity
			nre = clip_coord(((zre * zre - zim * zim) >>> FRAC_BITS) + cre);
			nim = clip_coord(((zre * zim) >>> (FRAC_BITS - 1)) + cim);
			zre = nre;
			zim = nim;
			rr = zre * zre;
			ii = zim * zim;
			mag = rr + ii;
			if (mag > thresh) begin
				break;
			end
			n++;
		end
		k = 0;
		if (n != lim) begin
			k = 255;
			while (k > 0 && k * k * lim > longint'(BRIGHT_SCALE) * n) begin
				k--;
			end
		end
		o.brightness = 8'(k);
		o.iter_count = 16'(n);
		return o;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTED) begin
			$display("mismatch at %0t: %s", $realtime, msg);
		end
	endtask

	task automatic queue_pixel(input logic [IDX_W-1:0] c, input logic [IDX_W-1:0] r);
		pending_pixels.push_back('{col: c, row: r});
		pixels_queued++;
	endtask

	task automatic plan_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		reg_plan.push_back('{index: idx, data: d});
	endtask

	// send every planned register write, one word per handshake, and track the shadow
	task automatic program_registers();
		reg_write_t w;
		while (reg_plan.size() > 0) begin
			w = reg_plan.pop_front();
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= w.index;
			cfg_ch.data  <= w.data;
			do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
			case (w.index)
				CFG_JULIA_MODE: regs.julia_mode = w.data[0];
				CFG_ORIGIN_RE:  regs.origin_re  = w.data;
				CFG_ORIGIN_IM:  regs.origin_im  = w.data;
				CFG_PIXEL_STEP: regs.pixel_step = w.data[STEP_W-1:0];
				CFG_CONST_RE:   regs.const_re   = w.data;
				CFG_CONST_IM:   regs.const_im   = w.data;
				CFG_MAX_ITER:   regs.max_iter   = w.data[ITER_OUT_W-1:0];
				CFG_ESCAPE_SQ:  regs.escape_sq  = w.data;
				default: ;   // unmapped index, the unit drops the write
			endcase
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// every queued pixel accepted and every result back
	task automatic await_idle();
		while (pixels_queued != inputs_accepted || results_checked != inputs_accepted) begin
			@(posedge clk);
		end
	endtask

	// pixel driver: gaps between words drawn at random unless the flow is steady, valid held until the unit takes the word
	always @(posedge clk or negedge arst_n) begin
		pixel_word_t nxt;
		if (!arst_n) begin
			pixel_ch.valid  <= 1'b0;
			pixel_ch.col    <= '0;
			pixel_ch.row    <= '0;
			predicted_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (pixel_ch.valid && pixel_ch.ready) begin
				predicted_word  <= escape_time(pixel_ch.col, pixel_ch.row, regs);
				predicted_valid <= 1'b1;
				inputs_accepted <= inputs_accepted + 1;
				send_gap = steady_flow ? 0 : $urandom_range(0, 5);
			end else begin
				predicted_valid <= 1'b0;
				if (!pixel_ch.valid && send_gap > 0) begin
					send_gap--;
				end
			end
			// the slot is free after this edge: offer the next word or go idle
			if (!pixel_ch.valid || pixel_ch.ready) begin
				if (send_gap == 0 && pending_pixels.size() > 0) begin
					nxt = pending_pixels.pop_front();
					pixel_ch.valid <= 1'b1;
					pixel_ch.col   <= nxt.col;
					pixel_ch.row   <= nxt.row;
				end else begin
					pixel_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-offs: the result register fills, then the core, then the input stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left    <= 0;
			next_hold_at <= HOLD_FIRST_AT;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (inputs_accepted >= next_hold_at) begin
			hold_left    <= HOLD_CYCLES;
			next_hold_at <= next_hold_at + HOLD_SPACING;
		end
	end

	// result monitor: compare each accepted word with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		pixel_result_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			sink_wait = 0;
		end else begin
			// a prediction always predates its result, so push first
			if (predicted_valid) begin
				expected_results.push_back(predicted_word);
			end
			if (result_ch.valid && result_ch.ready) begin
				results_checked <= results_checked + 1;
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected word brightness %0d iter_count %0d",
						result_ch.brightness, result_ch.iter_count));
				end else begin
					want = expected_results.pop_front();
					if (result_ch.iter_count !== want.iter_count) begin
						report_mismatch($sformatf("result %0d iter_count %0d, expected %0d",
							results_checked, result_ch.iter_count, want.iter_count));
					end
					if (result_ch.brightness !== want.brightness) begin
						report_mismatch($sformatf("result %0d brightness %0d, expected %0d",
							results_checked, result_ch.brightness, want.brightness));
					end
				end
				sink_wait = steady_flow ? 0 : $urandom_range(0, 5);
			end else if (result_ch.valid && sink_wait > 0) begin
				// the stall only runs down while a word is actually waiting
				sink_wait--;
			end
			result_ch.ready <= (hold_left == 0) && (sink_wait == 0);
		end
	end

	// watchdog on cycles with no word moving on any channel
	always @(posedge clk) begin
		if (!arst_n || (pixel_ch.valid && pixel_ch.ready) || (result_ch.valid && result_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", quiet_cycles);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		int          ph;
		int          i;
		int          shape;
		logic [31:0] w;
		logic [15:0] lim;
		logic [11:0] c;
		logic [11:0] r;

		// every input known from time zero
		pixel_ch.valid  = 1'b0;
		pixel_ch.col    = '0;
		pixel_ch.row    = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = '0;
		cfg_ch.data     = '0;

		regs.julia_mode = 1'b0;
		regs.origin_re  = RST_ORIGIN_RE;
		regs.origin_im  = RST_ORIGIN_IM;
		regs.pixel_step = RST_PIXEL_STEP;
		regs.const_re   = '0;
		regs.const_im   = '0;
		regs.max_iter   = RST_MAX_ITER;
		regs.escape_sq  = RST_ESCAPE_SQ;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset view from -2 at 1/256 per pixel: corners, far points, and known interior points
		queue_pixel(12'd0, 12'd0);
		queue_pixel(12'd4095, 12'd4095);
		queue_pixel(12'd0, 12'd4095);
		queue_pixel(12'd4095, 12'd0);
		queue_pixel(12'd512, 12'd512);    // origin, runs to the limit
		queue_pixel(12'd256, 12'd512);    // -1, period-two orbit
		queue_pixel(12'd576, 12'd512);    // the cusp at 0.25
		queue_pixel(12'd448, 12'd512);    // -0.25, inside
		queue_pixel(12'd600, 12'd700);
		await_idle();

		// zero limit: nothing iterates; a write to an unmapped index must change nothing
		plan_write(CFG_MAX_ITER, 32'd0);
		plan_write(4'(CFG_ESCAPE_SQ) + 4'd1, 32'hFFFF_FFFF);
		program_registers();
		queue_pixel(12'd512, 12'd512);
		queue_pixel(12'd4095, 12'd0);
		await_idle();

		// julia mode with the constant -0.8 + 0.156i
		plan_write(CFG_JULIA_MODE, 32'd1);
		plan_write(CFG_CONST_RE, -32'sd53687091);
		plan_write(CFG_CONST_IM, 32'sd10468982);
		plan_write(CFG_ORIGIN_RE, 32'hFC00_0000);
		plan_write(CFG_ORIGIN_IM, 32'hFC00_0000);
		plan_write(CFG_PIXEL_STEP, 32'h0002_0000);
		plan_write(CFG_MAX_ITER, 32'd64);
		program_registers();
		queue_pixel(12'd0, 12'd0);
		queue_pixel(12'd512, 12'd512);
		queue_pixel(12'd1023, 12'd1023);
		queue_pixel(12'd300, 12'd700);
		await_idle();

		// coordinate, step and threshold fields at their extremes: mapping and iteration both saturate
		plan_write(CFG_CONST_RE, 32'h8000_0000);
		plan_write(CFG_CONST_IM, 32'h7FFF_FFFF);
		plan_write(CFG_ORIGIN_RE, 32'h7FFF_FFFF);
		plan_write(CFG_ORIGIN_IM, 32'h8000_0000);
		plan_write(CFG_PIXEL_STEP, 32'hFFFF_FFFF);
		plan_write(CFG_ESCAPE_SQ, 32'hFFFF_FFFF);
		plan_write(CFG_MAX_ITER, 32'd1);
		program_registers();
		queue_pixel(12'd0, 12'd0);
		queue_pixel(12'd4095, 12'd4095);
		queue_pixel(12'd1, 12'd0);
		await_idle();

		// zero threshold, zero step, full limit: the origin never escapes, 65535 rounds
		plan_write(CFG_JULIA_MODE, 32'd0);
		plan_write(CFG_ORIGIN_RE, 32'd0);
		plan_write(CFG_ORIGIN_IM, 32'd0);
		plan_write(CFG_PIXEL_STEP, 32'd0);
		plan_write(CFG_ESCAPE_SQ, 32'd0);
		plan_write(CFG_MAX_ITER, 32'd65535);
		program_registers();
		queue_pixel(12'd2048, 12'd1234);
		await_idle();

		// random settings, each followed by a batch of random pixels
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			steady_flow = (ph % 4 == 3);
			shape = $urandom_range(0, 9);
			// only bit 0 counts, upper bits are noise
			plan_write(CFG_JULIA_MODE, $urandom);
			if (shape < 7) begin
				// a viewport over the interesting part of the plane
				plan_write(CFG_ORIGIN_RE, 32'hF600_0000 + $urandom_range(0, 32'h0400_0000));
				plan_write(CFG_ORIGIN_IM, 32'hF800_0000 + $urandom_range(0, 32'h0400_0000));
				w = $urandom_range(32'h0000_0800, 32'h0000_8000);
				plan_write(CFG_PIXEL_STEP, w | ($urandom & 32'h8000_0000));
				plan_write(CFG_CONST_RE, 32'hFA00_0000 + $urandom_range(0, 32'h0C00_0000));
				plan_write(CFG_CONST_IM, 32'hFA00_0000 + $urandom_range(0, 32'h0C00_0000));
			end else begin
				plan_write(CFG_ORIGIN_RE, $urandom);
				plan_write(CFG_ORIGIN_IM, $urandom);
				plan_write(CFG_PIXEL_STEP, $urandom);
				plan_write(CFG_CONST_RE, $urandom);
				plan_write(CFG_CONST_IM, $urandom);
			end
			case ($urandom_range(0, 7))
				0: lim = 16'($urandom_range(0, 1));
				1: lim = 16'd2;
				2, 3, 4: lim = 16'($urandom_range(3, 64));
				5: lim = 16'($urandom_range(65, 256));
				6: lim = 16'd255;
				default: lim = 16'd256;
			endcase
			plan_write(CFG_MAX_ITER, {16'($urandom), lim});
			case ($urandom_range(0, 5))
				0: w = 32'h0000_0000;
				1: w = 32'hFFFF_FFFF;
				2: w = $urandom;
				default: w = 32'h1000_0000;
			endcase
			plan_write(CFG_ESCAPE_SQ, w);
			if (ph == 5) begin
				// full limit on points just right of 2.0: a few rounds each, brightness
				// scaled against the largest limit
				plan_write(CFG_JULIA_MODE, 32'd0);
				plan_write(CFG_ORIGIN_RE, 32'h0800_0000);
				plan_write(CFG_ORIGIN_IM, 32'd0);
				plan_write(CFG_PIXEL_STEP, $urandom_range(32'h0000_1000, 32'h0000_4000));
				plan_write(CFG_MAX_ITER, 32'd65535);
				plan_write(CFG_ESCAPE_SQ, 32'hFFFF_FFFF);
			end
			plan_write(4'(CFG_ESCAPE_SQ) + 4'($urandom_range(1, 8)), $urandom);
			program_registers();
			for (i = 0; i < PHASE_PIXELS; i++) begin
				c = 12'($urandom_range(0, 4095));
				r = 12'($urandom_range(0, 4095));
				if ($urandom_range(0, 15) == 0) begin
					c = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
				end
				if ($urandom_range(0, 15) == 0) begin
					r = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
				end
				queue_pixel(c, r);
			end
			await_idle();
		end

		// let anything stray show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
